// ===== hdl/wsp_pkg.sv =====
// Shared constants, types and helpers for the world-to-screen projection pipeline
`timescale 1ns / 1ps

package wsp_pkg;

   localparam int DATA_W    = 32;
   localparam int FRAC_BITS = 16;
   localparam int PROD_W    = 2 * DATA_W - FRAC_BITS;   // Q32.32 product floored to Q32.16
   localparam int CLIP_W    = 50;                        // exact sum of three products + offset
   localparam int DIV_BITS  = 31;                        // quotient bits below saturation
   localparam int SAT_W     = CLIP_W + FRAC_BITS - 1;
   localparam int DIV_W     = CLIP_W + DIV_BITS;
   localparam int DIM_W     = 14;
   localparam int HALF_W    = DIM_W - 1;
   localparam int MUL_W     = DIM_W + 1 + DATA_W;
   localparam int SUM_W     = MUL_W + 1;
   localparam int COEF_N    = 16;
   localparam int IDX_W     = $clog2(COEF_N);
   localparam int ROWS      = 3;

   localparam logic signed [CLIP_W-1:0] W_MIN = CLIP_W'(6554);   // 0.1 in Q16.16
   localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(1920);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(1080);

   localparam logic MODE_LOAD    = 1'b0;
   localparam logic MODE_PROJECT = 1'b1;

   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   // store entries of the x, y and w rows
   localparam int ROW_BASE [ROWS] = '{0, 4, 12};

   typedef struct packed {
      logic vis;
      logic neg_x;
      logic neg_y;
      logic sat_x;
      logic sat_y;
   } div_tag_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > SUM_W'(Q_MAX)) begin
         r = Q_MAX;
      end else if (v < SUM_W'(Q_MIN)) begin
         r = Q_MIN;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== hdl/wsp_req_if.sv =====
// Input channel: coefficient loads and points to project
`timescale 1ns / 1ps

interface wsp_req_if;
   logic               valid;
   logic               ready;
   logic               mode;
   logic [3:0]         coef_index;
   logic signed [31:0] coef_value;
   logic signed [31:0] world_x;
   logic signed [31:0] world_y;
   logic signed [31:0] world_z;

   modport source(output valid, mode, coef_index, coef_value, world_x, world_y, world_z,
                  input ready);
   modport sink(input valid, mode, coef_index, coef_value, world_x, world_y, world_z,
                output ready);
endinterface

// ===== hdl/wsp_rsp_if.sv =====
// Result channel: screen coordinates and visibility
`timescale 1ns / 1ps

interface wsp_rsp_if;
   logic               valid;
   logic               ready;
   logic               visible;
   logic signed [31:0] screen_x;
   logic signed [31:0] screen_y;

   modport source(output valid, visible, screen_x, screen_y, input ready);
   modport sink(input valid, visible, screen_x, screen_y, output ready);
endinterface

// ===== hdl/wsp_clip.sv =====
// Matrix store and two-stage clip-space transform (multiply, then sum)
`timescale 1ns / 1ps

module wsp_clip (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               adv,
   input  logic                               proj_en,
   input  logic                               load_en,
   input  logic [wsp_pkg::IDX_W-1:0]          coef_index,
   input  logic signed [wsp_pkg::DATA_W-1:0]  coef_value,
   input  logic signed [wsp_pkg::DATA_W-1:0]  world_x,
   input  logic signed [wsp_pkg::DATA_W-1:0]  world_y,
   input  logic signed [wsp_pkg::DATA_W-1:0]  world_z,
   output logic                               valid_out,
   output logic signed [wsp_pkg::CLIP_W-1:0]  clip_x,
   output logic signed [wsp_pkg::CLIP_W-1:0]  clip_y,
   output logic signed [wsp_pkg::CLIP_W-1:0]  clip_w
);

   logic signed [wsp_pkg::DATA_W-1:0] store_ff [wsp_pkg::COEF_N];
   logic signed [wsp_pkg::DATA_W-1:0] coord [3];

   logic signed [wsp_pkg::PROD_W-1:0] prod_in [wsp_pkg::ROWS][3];
   logic signed [wsp_pkg::PROD_W-1:0] prod_ff [wsp_pkg::ROWS][3];
   logic signed [wsp_pkg::DATA_W-1:0] tr_in [wsp_pkg::ROWS];
   logic signed [wsp_pkg::DATA_W-1:0] tr_ff [wsp_pkg::ROWS];
   logic signed [wsp_pkg::CLIP_W-1:0] sum_in [wsp_pkg::ROWS];
   logic signed [wsp_pkg::CLIP_W-1:0] sum_ff [wsp_pkg::ROWS];
   logic                              v1_ff;
   logic                              v2_ff;

   assign coord[0] = world_x;
   assign coord[1] = world_y;
   assign coord[2] = world_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < wsp_pkg::COEF_N; i++) begin
            store_ff[i] <= '0;
         end
      end else if (load_en) begin
         store_ff[coef_index] <= coef_value;
      end
   end

   // arithmetic shift of the exact product floors it to Q32.16
   always_comb begin
      logic signed [2*wsp_pkg::DATA_W-1:0] full;
      full = '0;
      for (int r = 0; r < wsp_pkg::ROWS; r++) begin
         for (int c = 0; c < 3; c++) begin
            full = coord[c] * store_ff[wsp_pkg::IDX_W'(wsp_pkg::ROW_BASE[r] + c)];
            prod_in[r][c] = full[2*wsp_pkg::DATA_W-1:wsp_pkg::FRAC_BITS];
         end
         tr_in[r] = store_ff[wsp_pkg::IDX_W'(wsp_pkg::ROW_BASE[r] + 3)];
      end
   end

   always_comb begin
      for (int r = 0; r < wsp_pkg::ROWS; r++) begin
         sum_in[r] = wsp_pkg::CLIP_W'(prod_ff[r][0]) + wsp_pkg::CLIP_W'(prod_ff[r][1])
                   + wsp_pkg::CLIP_W'(prod_ff[r][2]) + wsp_pkg::CLIP_W'(tr_ff[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= proj_en;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         tr_ff   <= tr_in;
         sum_ff  <= sum_in;
      end
   end

   assign valid_out = v2_ff;
   assign clip_x    = sum_ff[0];
   assign clip_y    = sum_ff[1];
   assign clip_w    = sum_ff[2];

endmodule

// ===== hdl/wsp_div.sv =====
// Pipelined restoring divider for x/w and y/w, one quotient bit per stage
`timescale 1ns / 1ps

module wsp_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               adv,
   input  logic                               valid_in,
   input  logic signed [wsp_pkg::CLIP_W-1:0]  clip_x,
   input  logic signed [wsp_pkg::CLIP_W-1:0]  clip_y,
   input  logic signed [wsp_pkg::CLIP_W-1:0]  clip_w,
   output logic                               valid_out,
   output logic [wsp_pkg::DIV_BITS-1:0]       quot_x,
   output logic [wsp_pkg::DIV_BITS-1:0]       quot_y,
   output wsp_pkg::div_tag_type               tag_out
);

   localparam int NS = wsp_pkg::DIV_BITS;

   // magnitude stage
   logic                         a_valid_ff;
   logic [wsp_pkg::CLIP_W-1:0]   ax_ff, ay_ff, ad_ff;
   logic [wsp_pkg::CLIP_W-1:0]   ax_in, ay_in;
   wsp_pkg::div_tag_type         a_tag_ff, a_tag_in;

   logic                         valid_ff [NS+1];
   logic [wsp_pkg::DIV_W-1:0]    rx_ff [NS+1];
   logic [wsp_pkg::DIV_W-1:0]    ry_ff [NS+1];
   logic [NS-1:0]                qx_ff [NS+1];
   logic [NS-1:0]                qy_ff [NS+1];
   logic [wsp_pkg::CLIP_W-1:0]   dn_ff [NS+1];
   wsp_pkg::div_tag_type         tag_ff [NS+1];
   wsp_pkg::div_tag_type         b_tag_in;
   logic [wsp_pkg::SAT_W-1:0]    lim;

   always_comb begin
      ax_in = clip_x[wsp_pkg::CLIP_W-1] ? wsp_pkg::CLIP_W'(-clip_x) : wsp_pkg::CLIP_W'(clip_x);
      ay_in = clip_y[wsp_pkg::CLIP_W-1] ? wsp_pkg::CLIP_W'(-clip_y) : wsp_pkg::CLIP_W'(clip_y);
      a_tag_in       = '0;
      a_tag_in.vis   = (clip_w >= wsp_pkg::W_MIN);
      a_tag_in.neg_x = clip_x[wsp_pkg::CLIP_W-1];
      a_tag_in.neg_y = clip_y[wsp_pkg::CLIP_W-1];
   end

   // integer part of 2^15 or more saturates
   always_comb begin
      lim            = wsp_pkg::SAT_W'(ad_ff) << (wsp_pkg::FRAC_BITS - 1);
      b_tag_in       = a_tag_ff;
      b_tag_in.sat_x = (wsp_pkg::SAT_W'(ax_ff) >= lim);
      b_tag_in.sat_y = (wsp_pkg::SAT_W'(ay_ff) >= lim);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff  <= 1'b0;
         valid_ff[0] <= 1'b0;
      end else if (adv) begin
         a_valid_ff  <= valid_in;
         valid_ff[0] <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ax_ff     <= ax_in;
         ay_ff     <= ay_in;
         ad_ff     <= wsp_pkg::CLIP_W'(clip_w);
         a_tag_ff  <= a_tag_in;
         rx_ff[0]  <= wsp_pkg::DIV_W'(ax_ff) << wsp_pkg::FRAC_BITS;
         ry_ff[0]  <= wsp_pkg::DIV_W'(ay_ff) << wsp_pkg::FRAC_BITS;
         qx_ff[0]  <= '0;
         qy_ff[0]  <= '0;
         dn_ff[0]  <= ad_ff;
         tag_ff[0] <= b_tag_in;
      end
   end

   for (genvar s = 1; s <= NS; s++) begin : g_bit
      logic [wsp_pkg::DIV_W-1:0] trial;
      logic                      ge_x, ge_y;

      assign trial = wsp_pkg::DIV_W'(dn_ff[s-1]) << (NS - s);
      assign ge_x  = (rx_ff[s-1] >= trial);
      assign ge_y  = (ry_ff[s-1] >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (adv) begin
            valid_ff[s] <= valid_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rx_ff[s]  <= ge_x ? rx_ff[s-1] - trial : rx_ff[s-1];
            ry_ff[s]  <= ge_y ? ry_ff[s-1] - trial : ry_ff[s-1];
            qx_ff[s]  <= {qx_ff[s-1][NS-2:0], ge_x};
            qy_ff[s]  <= {qy_ff[s-1][NS-2:0], ge_y};
            dn_ff[s]  <= dn_ff[s-1];
            tag_ff[s] <= tag_ff[s-1];
         end
      end
   end

   assign valid_out = valid_ff[NS];
   assign quot_x    = qx_ff[NS];
   assign quot_y    = qy_ff[NS];
   assign tag_out   = tag_ff[NS];

endmodule

// ===== hdl/wsp_map.sv =====
// Viewport mapping: sign and saturate, scale by half extents, offset, zero hidden points and output register
`timescale 1ns / 1ps

module wsp_map (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               adv,
   input  logic                               valid_in,
   input  logic [wsp_pkg::DIV_BITS-1:0]       quot_x,
   input  logic [wsp_pkg::DIV_BITS-1:0]       quot_y,
   input  wsp_pkg::div_tag_type               tag_in,
   input  logic [wsp_pkg::HALF_W-1:0]         half_w,
   input  logic [wsp_pkg::HALF_W-1:0]         half_h,
   output logic                               valid_out,
   output logic                               visible,
   output logic signed [wsp_pkg::DATA_W-1:0]  screen_x,
   output logic signed [wsp_pkg::DATA_W-1:0]  screen_y
);

   logic                                m1_valid_ff, m2_valid_ff, out_valid_ff;
   logic                                m1_vis_ff, m2_vis_ff, vis_ff;
   logic signed [wsp_pkg::DATA_W-1:0]   nx_in, ny_in, nx_ff, ny_ff;
   logic [wsp_pkg::DIM_W-1:0]           kx;
   logic signed [wsp_pkg::DIM_W:0]      ky;
   logic signed [wsp_pkg::MUL_W-1:0]    px_in, py_in, px_ff, py_ff;
   logic [wsp_pkg::HALF_W-1:0]          hw_ff, hh_ff;
   logic signed [wsp_pkg::SUM_W-1:0]    sx_sum, sy_sum;
   logic signed [wsp_pkg::DATA_W-1:0]   sx_in, sy_in, sx_ff, sy_ff;

   always_comb begin
      if (tag_in.sat_x) begin
         nx_in = tag_in.neg_x ? wsp_pkg::Q_MIN : wsp_pkg::Q_MAX;
      end else if (tag_in.neg_x) begin
         nx_in = -$signed(wsp_pkg::DATA_W'(quot_x));
      end else begin
         nx_in = $signed(wsp_pkg::DATA_W'(quot_x));
      end
      if (tag_in.sat_y) begin
         ny_in = tag_in.neg_y ? wsp_pkg::Q_MIN : wsp_pkg::Q_MAX;
      end else if (tag_in.neg_y) begin
         ny_in = -$signed(wsp_pkg::DATA_W'(quot_y));
      end else begin
         ny_in = $signed(wsp_pkg::DATA_W'(quot_y));
      end
   end

   // x scale is hw + 1, y scale is 1 - hh (flipped axis)
   always_comb begin
      kx    = wsp_pkg::DIM_W'(half_w) + wsp_pkg::DIM_W'(1);
      ky    = (wsp_pkg::DIM_W+1)'(1) - $signed((wsp_pkg::DIM_W+1)'(half_h));
      px_in = $signed({1'b0, kx}) * nx_ff;
      py_in = ky * ny_ff;
   end

   always_comb begin
      sx_sum = wsp_pkg::SUM_W'(px_ff)
             + $signed(wsp_pkg::SUM_W'({hw_ff, {wsp_pkg::FRAC_BITS{1'b0}}}));
      sy_sum = wsp_pkg::SUM_W'(py_ff)
             + $signed(wsp_pkg::SUM_W'({hh_ff, {wsp_pkg::FRAC_BITS{1'b0}}}));
      if (m2_vis_ff) begin
         sx_in = wsp_pkg::sat32(sx_sum);
         sy_in = wsp_pkg::sat32(sy_sum);
      end else begin
         sx_in = '0;
         sy_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff  <= 1'b0;
         m2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         m1_valid_ff  <= valid_in;
         m2_valid_ff  <= m1_valid_ff;
         out_valid_ff <= m2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nx_ff     <= nx_in;
         ny_ff     <= ny_in;
         m1_vis_ff <= tag_in.vis;
         px_ff     <= px_in;
         py_ff     <= py_in;
         hw_ff     <= half_w;
         hh_ff     <= half_h;
         m2_vis_ff <= m1_vis_ff;
         sx_ff     <= sx_in;
         sy_ff     <= sy_in;
         vis_ff    <= m2_vis_ff;
      end
   end

   assign valid_out = out_valid_ff;
   assign visible   = vis_ff;
   assign screen_x  = sx_ff;
   assign screen_y  = sy_ff;

endmodule

// ===== hdl/world_to_screen_projection_top.sv =====
// Top level: projection pipeline, viewport registers and configuration port
//
// Usage:
//  req_chan takes two kinds of transfer. mode 0 writes coef_index/coef_value
//  into the 4x4 row-major Q16.16 matrix and gives no result; mode 1 projects
//  world_x/y/z and gives exactly one transfer on rsp_chan.
//  A load takes effect for every point accepted after it.
//  Pipeline: a point passes 2 clip stages, 2 divider set-up stages,
//  31 quotient-bit stages and 3 mapping stages before its result is
//  presented. One item is taken per cycle while rsp_chan does not stall;
//  the 31-stage restoring divider sets the depth, not the rate.
//  Stall: when rsp_chan is not ready and a result is waiting, every stage
//  holds and req_chan.ready drops; nothing is lost or repeated.
//  Reset clears the matrix to zero, the viewport to 1920 x 1080 and all
//  valid bits. The viewport registers (width at 0x0, height at 0x4) sit on
//  the APB port; the user must see they are written only while the pipeline
//  is empty, as the block itself does not enforce it.
`timescale 1ns / 1ps

module world_to_screen_projection_top (
   input  logic         clock,
   input  logic         reset,
   wsp_req_if.sink      req_chan,
   wsp_rsp_if.source    rsp_chan,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   logic                              adv;
   logic                              accept, load_en, proj_en, cfg_wr;
   logic [wsp_pkg::DIM_W-1:0]         width_ff, height_ff;
   logic                              clip_valid, div_valid, map_valid;
   logic signed [wsp_pkg::CLIP_W-1:0] clip_x, clip_y, clip_w;
   logic [wsp_pkg::DIV_BITS-1:0]      quot_x, quot_y;
   wsp_pkg::div_tag_type              div_tag;

   // output register is the only place a result waits
   assign adv            = !map_valid || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign accept         = req_chan.valid && adv;
   assign load_en        = accept && (req_chan.mode == wsp_pkg::MODE_LOAD);
   assign proj_en        = accept && (req_chan.mode == wsp_pkg::MODE_PROJECT);

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;
   assign prdata = (paddr[2] == wsp_pkg::REG_HEIGHT) ? 32'(height_ff) : 32'(width_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= wsp_pkg::WIDTH_RESET;
         height_ff <= wsp_pkg::HEIGHT_RESET;
      end else if (cfg_wr) begin
         if (paddr[2] == wsp_pkg::REG_WIDTH) begin
            width_ff <= pwdata[wsp_pkg::DIM_W-1:0];
         end else begin
            height_ff <= pwdata[wsp_pkg::DIM_W-1:0];
         end
      end
   end

   wsp_clip u_clip (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .proj_en    (proj_en),
      .load_en    (load_en),
      .coef_index (req_chan.coef_index),
      .coef_value (req_chan.coef_value),
      .world_x    (req_chan.world_x),
      .world_y    (req_chan.world_y),
      .world_z    (req_chan.world_z),
      .valid_out  (clip_valid),
      .clip_x     (clip_x),
      .clip_y     (clip_y),
      .clip_w     (clip_w)
   );

   wsp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .valid_in  (clip_valid),
      .clip_x    (clip_x),
      .clip_y    (clip_y),
      .clip_w    (clip_w),
      .valid_out (div_valid),
      .quot_x    (quot_x),
      .quot_y    (quot_y),
      .tag_out   (div_tag)
   );

   wsp_map u_map (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .valid_in  (div_valid),
      .quot_x    (quot_x),
      .quot_y    (quot_y),
      .tag_in    (div_tag),
      .half_w    (width_ff[wsp_pkg::DIM_W-1:1]),
      .half_h    (height_ff[wsp_pkg::DIM_W-1:1]),
      .valid_out (map_valid),
      .visible   (rsp_chan.visible),
      .screen_x  (rsp_chan.screen_x),
      .screen_y  (rsp_chan.screen_y)
   );

   assign rsp_chan.valid = map_valid;

   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.visible) |-> (rsp_chan.screen_x == 0 && rsp_chan.screen_y == 0))
      else $error("hidden point with non-zero coordinates");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result presented straight after reset");

   a_width_write: assert property (@(posedge clock) disable iff (reset)
      (cfg_wr && paddr[2] == wsp_pkg::REG_WIDTH) |=> (width_ff == $past(pwdata[13:0])))
      else $error("width register write lost");

endmodule
